@@ sv/crse_pkg.sv @@
// Shared types and constants for the coterminal swap rate engine.
package crse_pkg;

  localparam logic [47:0] ONE_Q32     = 48'h0001_0000_0000;
  localparam logic [47:0] MAX48       = 48'hFFFF_FFFF_FFFF;
  localparam logic [6:0]  MAX_PERIODS = 7'd64;
  localparam logic [31:0] SWAP_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SWAP_NEG_MAX = 32'h8000_0000;

  typedef struct packed {
    logic signed [31:0] forward_rate;
    logic [31:0]        accrual;
    logic               restart;
  } in_word_t;

  typedef struct packed {
    logic [6:0]         position;
    logic [47:0]        discount_ratio;
    logic [47:0]        annuity;
    logic signed [31:0] swap_rate;
    logic               saturated;
    logic               zero_annuity;
  } out_word_t;

  // Classified period as handed from the front end to the back end.
  typedef struct packed {
    logic [37:0] factor;
    logic        kill;
    logic [31:0] tau;
    logic        restart;
  } job_t;

endpackage

@@ sv/crse_front.sv @@
// Front end: accepts input words and turns each into a growth factor job.
module crse_front import crse_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_word_t in_word,
  output logic     push,
  output job_t     push_job,
  input  logic     q_full
);

  logic        stage_valid;
  logic [31:0] fmag;
  logic        f_neg;
  logic [31:0] tau;
  logic        restart;
  logic [63:0] prod;
  logic [36:0] d;

  assign push     = stage_valid && !q_full;
  assign in_ready = !stage_valid || push;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f_neg   <= in_word.forward_rate[31];
      fmag    <= in_word.forward_rate[31] ? (32'd0 - in_word.forward_rate)
                                          : in_word.forward_rate;
      tau     <= in_word.accrual;
      restart <= in_word.restart;
    end
  end

  always_comb begin
    prod = fmag * tau;
    d    = prod[62:26];
    push_job.tau     = tau;
    push_job.restart = restart;
    push_job.kill    = 1'b0;
    if (!f_neg) begin
      push_job.factor = {6'd0, ONE_Q32[31:0]} + {1'b0, d} + 38'h1_0000_0000
                        - {6'd0, ONE_Q32[31:0]};
    end else if ({1'b0, d} <= 38'h1_0000_0000) begin
      push_job.factor = 38'h1_0000_0000 - {1'b0, d};
    end else begin
      push_job.factor = '0;
      push_job.kill   = 1'b1;
    end
  end

endmodule

@@ sv/crse_queue.sv @@
// Two-entry queue of jobs between the front end and the back end.
module crse_queue import crse_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic avail,
  output job_t pop_job
);

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign avail   = (count != 2'd0);
  assign pop_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

@@ sv/crse_back.sv @@
// Back end: multiply-accumulate sequencer, iterative divider and output register.
module crse_back import crse_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      avail,
  input  job_t      pop_job,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL   = 6'b000010,
    S_RATIO = 6'b000100,
    S_NUM   = 6'b001000,
    S_DIV   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t      state;
  logic [2:0]  step;
  logic [4:0]  div_cnt;
  job_t        job;
  logic [47:0] prev;
  logic [47:0] running_ratio;
  logic [47:0] running_annuity;
  logic [6:0]  period_count;
  logic [95:0] acc;
  logic        sat;
  logic        zero_ann;
  logic        big;
  logic        num_neg;
  logic [47:0] num;
  logic [47:0] rem;
  logic [31:0] q;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [1:0]  mul_sh;
  logic [63:0] mul_p;
  logic [95:0] acc_next;
  logic [47:0] term;
  logic        term_sat;
  logic [48:0] ann_sum;
  logic [48:0] rem2;
  logic [49:0] ann3;
  logic        load_out;
  logic [31:0] swap;
  logic        swap_sat;

  assign pop = (state == S_IDLE) && avail;

  // Operand selection of the shared 32x32 multiplier.
  always_comb begin
    case (step)
      3'd0: begin mul_a = job.tau; mul_b = prev[31:0]; mul_sh = 2'd0; end
      3'd1: begin mul_a = job.tau; mul_b = {16'd0, prev[47:32]}; mul_sh = 2'd1; end
      3'd2: begin mul_a = prev[31:0]; mul_b = job.factor[31:0]; mul_sh = 2'd0; end
      3'd3: begin mul_a = prev[31:0]; mul_b = {26'd0, job.factor[37:32]}; mul_sh = 2'd1; end
      3'd4: begin mul_a = {16'd0, prev[47:32]}; mul_b = job.factor[31:0]; mul_sh = 2'd1; end
      3'd5: begin
        mul_a = {16'd0, prev[47:32]}; mul_b = {26'd0, job.factor[37:32]}; mul_sh = 2'd2;
      end
      default: begin mul_a = '0; mul_b = '0; mul_sh = 2'd0; end
    endcase
    mul_p = mul_a * mul_b;
    case (mul_sh)
      2'd1:    acc_next = {mul_p, 32'd0};
      2'd2:    acc_next = {mul_p[31:0], 64'd0};
      default: acc_next = {32'd0, mul_p};
    endcase
    if (step == 3'd0 || step == 3'd2) begin
      acc_next = acc_next;
    end else begin
      acc_next = acc + acc_next;
    end
  end

  // Annuity term from the finished tau * prev product.
  always_comb begin
    term_sat = (acc[95:76] != 20'd0);
    term     = term_sat ? MAX48 : acc[75:28];
    ann_sum  = {1'b0, running_annuity} + {1'b0, term};
  end

  assign rem2 = {rem, 1'b0};
  assign ann3 = {1'b0, running_annuity, 1'b0} + {2'd0, running_annuity};

  always_comb begin
    swap_sat = 1'b0;
    if (zero_ann) begin
      swap = '0;
    end else if (big) begin
      swap_sat = 1'b1;
      swap = num_neg ? SWAP_NEG_MAX : SWAP_POS_MAX;
    end else if (!num_neg) begin
      swap_sat = (q > SWAP_POS_MAX);
      swap = swap_sat ? SWAP_POS_MAX : q;
    end else begin
      swap_sat = (q > SWAP_NEG_MAX);
      swap = swap_sat ? SWAP_NEG_MAX : (32'd0 - q);
    end
  end

  assign load_out = (state == S_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      step            <= 3'd0;
      div_cnt         <= 5'd0;
      running_ratio   <= ONE_Q32;
      running_annuity <= '0;
      period_count    <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (avail) begin
            job  <= pop_job;
            step <= 3'd0;
            sat  <= 1'b0;
            prev <= pop_job.restart ? ONE_Q32 : running_ratio;
            if (pop_job.restart) begin
              running_annuity <= '0;
              period_count    <= '0;
            end
            state <= S_MUL;
          end
        end
        S_MUL: begin
          acc <= acc_next;
          if (step == 3'd2) begin
            if (ann_sum[48]) begin
              running_annuity <= MAX48;
              sat <= 1'b1;
            end else begin
              running_annuity <= ann_sum[47:0];
              if (term_sat) sat <= 1'b1;
            end
          end
          if (step == 3'd5) begin
            state <= S_RATIO;
          end else begin
            step <= step + 3'd1;
          end
        end
        S_RATIO: begin
          if (job.kill) begin
            running_ratio <= '0;
            sat <= 1'b1;
          end else if (acc[95:80] != 16'd0) begin
            running_ratio <= MAX48;
            sat <= 1'b1;
          end else begin
            running_ratio <= acc[79:32];
          end
          if (period_count < MAX_PERIODS) period_count <= period_count + 7'd1;
          state <= S_NUM;
        end
        S_NUM: begin
          zero_ann <= (running_annuity == '0);
          num_neg  <= (running_ratio < ONE_Q32);
          num      <= (running_ratio < ONE_Q32) ? (ONE_Q32 - running_ratio)
                                                : (running_ratio - ONE_Q32);
          big      <= 1'b0;
          state    <= S_DIV;
          div_cnt  <= 5'd0;
          step     <= 3'd0;
        end
        S_DIV: begin
          if (zero_ann) begin
            state <= S_DONE;
          end else if (step == 3'd0) begin
            // Integer part of the quotient, at most two.
            step <= 3'd1;
            if ({2'd0, num} >= ann3) begin
              big   <= 1'b1;
              state <= S_DONE;
            end else if ({1'b0, num} >= {running_annuity, 1'b0}) begin
              q   <= 32'd2;
              rem <= num - {running_annuity[46:0], 1'b0};
            end else if (num >= running_annuity) begin
              q   <= 32'd1;
              rem <= num - running_annuity;
            end else begin
              q   <= 32'd0;
              rem <= num;
            end
          end else begin
            if (rem2 >= {1'b0, running_annuity}) begin
              rem <= 48'(rem2 - {1'b0, running_annuity});
              q   <= {q[30:0], 1'b1};
            end else begin
              rem <= rem2[47:0];
              q   <= {q[30:0], 1'b0};
            end
            if (div_cnt == 5'd29) begin
              state <= S_DONE;
            end else begin
              div_cnt <= div_cnt + 5'd1;
            end
          end
        end
        S_DONE: begin
          if (load_out) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_word.position       <= period_count;
      out_word.discount_ratio <= running_ratio;
      out_word.annuity        <= running_annuity;
      out_word.swap_rate      <= swap;
      out_word.saturated      <= sat | swap_sat;
      out_word.zero_annuity   <= zero_ann;
    end
  end

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> state == S_IDLE) else $error("pop outside idle");
  a_zero_swap: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.zero_annuity |-> out_word.swap_rate == 0 && out_word.annuity == 0)
    else $error("zero annuity with nonzero swap rate");
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |-> step <= 3'd5) else $error("multiply step out of range");
  a_load_done: assert property (@(posedge clk) disable iff (rst)
    load_out |=> state == S_IDLE && out_valid) else $error("result load lost");
`endif

endmodule

@@ sv/coterminal_swap_rate_engine_top.sv @@
// Top level of the coterminal swap rate engine.
// Each input word carries one period's forward rate (Q2.30) and accrual (Q4.28), streamed
// from the terminal period backwards; restart marks the terminal period. For every word the
// block returns one result word with the period position, the discount ratio and annuity
// against the terminal bond (Q16.32) and the coterminal swap rate (Q2.30), plus saturation
// and zero-annuity flags. The front end takes a word in and computes the growth factor with
// one multiply; a two-entry queue passes it to the back end, which runs the ratio and annuity
// products through one shared 32x32 multiplier and then a restoring divider for the swap rate,
// one quotient bit per cycle. The back end takes the next word only after the last result is
// loaded into the output register; the front end and the output register let input and
// output stall independently of the back end.
module coterminal_swap_rate_engine_top import crse_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  logic push;
  job_t push_job;
  logic q_full;
  logic pop;
  logic avail;
  job_t pop_job;

  // Front end classifies each word into a job.
  crse_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .push     (push),
    .push_job (push_job),
    .q_full   (q_full)
  );

  // Short queue decouples the two halves.
  crse_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .avail    (avail),
    .pop_job  (pop_job)
  );

  // Back end carries the running state and produces results.
  crse_back u_back (
    .clk       (clk),
    .rst       (rst),
    .avail     (avail),
    .pop_job   (pop_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

@@ dv/tb_coterminal_swap_rate_engine_top.sv @@
// Testbench for the coterminal swap rate engine: directed table plus random periods.
`timescale 1ns / 100ps

module tb_coterminal_swap_rate_engine_top;
  import crse_pkg::*;

  localparam int N_RANDOM = 1650;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  // The receiver idles only while this is set; the final stretch of the run has no idling.
  bit        idle_enable = 1'b1;
  int        n_fail = 0;

  // Predictor state: the running ratio and annuity against the terminal bond, and the count
  // of periods folded in since the terminal one. It starts out as after reset.
  logic [47:0] curve_ratio = ONE_Q32;
  logic [47:0] curve_annuity = '0;
  logic [6:0]  curve_count = '0;

  // Expected result words, oldest first.
  out_word_t   pending_results[$];

  // One row of the directed table. When has_expect is set, the row's result is also compared
  // with the typed-in value, on top of the predictor check.
  typedef struct {
    in_word_t  word;
    bit        has_expect;
    out_word_t expect_word;
  } stim_row_t;

  always #5 clk = ~clk;

  coterminal_swap_rate_engine_top DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word(out_word)
  );

  // Product a*b shifted right by sh, clipped to 48 bits. The flag is raised on a clip.
  function automatic logic [47:0] scaled_product(input logic [63:0] a, input logic [63:0] b,
                                                 input int sh, inout bit clip);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> sh;
    if (p > {80'd0, MAX48}) begin
      clip = 1'b1;
      return MAX48;
    end
    return p[47:0];
  endfunction

  // Folds one period into the running curve and returns the result word the block must give.
  function automatic out_word_t fold_period(input in_word_t w);
    out_word_t    r;
    bit           clip;
    logic [31:0]  f;
    logic [32:0]  fmag;
    logic [63:0]  growth;
    logic [47:0]  prev;
    logic [48:0]  ann_sum;
    logic [47:0]  ratio;
    logic [47:0]  num;
    bit           num_neg;
    logic [127:0] q;
    clip = 1'b0;
    f = w.forward_rate;
    fmag = f[31] ? (33'h1_0000_0000 - {1'b0, f}) : {1'b0, f};
    if (w.restart) begin
      curve_ratio = ONE_Q32;
      curve_annuity = '0;
      curve_count = '0;
    end
    prev = curve_ratio;
    ann_sum = {1'b0, curve_annuity} +
              {1'b0, scaled_product({32'd0, w.accrual}, {16'd0, prev}, 28, clip)};
    if (ann_sum > {1'b0, MAX48}) begin
      ann_sum = {1'b0, MAX48};
      clip = 1'b1;
    end
    curve_annuity = ann_sum[47:0];
    growth = ({31'd0, fmag} * {32'd0, w.accrual}) >> 26;
    if (!f[31])
      ratio = scaled_product({16'd0, prev}, 64'h1_0000_0000 + growth, 32, clip);
    else if (growth <= 64'h1_0000_0000)
      ratio = scaled_product({16'd0, prev}, 64'h1_0000_0000 - growth, 32, clip);
    else begin
      // The growth factor went negative: the ratio floors at zero.
      ratio = '0;
      clip = 1'b1;
    end
    curve_ratio = ratio;
    if (curve_count < MAX_PERIODS) curve_count++;
    r = '0;
    if (curve_annuity == '0) begin
      r.zero_annuity = 1'b1;
    end else begin
      num_neg = ratio < ONE_Q32;
      num = num_neg ? (ONE_Q32 - ratio) : (ratio - ONE_Q32);
      q = ({80'd0, num} << 30) / {80'd0, curve_annuity};
      if (!num_neg) begin
        if (q > 128'h7FFF_FFFF) begin
          q = 128'h7FFF_FFFF;
          clip = 1'b1;
        end
        r.swap_rate = q[31:0];
      end else begin
        if (q > 128'h8000_0000) begin
          q = 128'h8000_0000;
          clip = 1'b1;
        end
        r.swap_rate = 32'd0 - q[31:0];
      end
    end
    r.position = curve_count;
    r.discount_ratio = curve_ratio;
    r.annuity = curve_annuity;
    r.saturated = clip;
    return r;
  endfunction

  function automatic bit compare_result(input out_word_t want, input out_word_t got);
    bit ok;
    ok = 1'b1;
    if (got.position !== want.position) begin
      $error("position: expected %0d, actual %0d", want.position, got.position);
      ok = 1'b0;
    end
    if (got.discount_ratio !== want.discount_ratio) begin
      $error("discount_ratio: expected %h, actual %h", want.discount_ratio, got.discount_ratio);
      ok = 1'b0;
    end
    if (got.annuity !== want.annuity) begin
      $error("annuity: expected %h, actual %h", want.annuity, got.annuity);
      ok = 1'b0;
    end
    if (got.swap_rate !== want.swap_rate) begin
      $error("swap_rate: expected %h, actual %h", want.swap_rate, got.swap_rate);
      ok = 1'b0;
    end
    if (got.saturated !== want.saturated) begin
      $error("saturated: expected %b, actual %b", want.saturated, got.saturated);
      ok = 1'b0;
    end
    if (got.zero_annuity !== want.zero_annuity) begin
      $error("zero_annuity: expected %b, actual %b", want.zero_annuity, got.zero_annuity);
      ok = 1'b0;
    end
    return ok;
  endfunction

  // Result side: every accepted word is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result word arrived with no expectation pending");
        n_fail++;
      end else if (!compare_result(pending_results.pop_front(), out_word)) begin
        n_fail++;
      end
    end
  end

  // Receiver back-pressure: random stall bursts of random length, changed on the falling edge.
  initial begin
    int burst;
    @(negedge clk);
    forever begin
      if (idle_enable && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 6);
        out_ready <= 1'b0;
        repeat (burst) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(negedge clk);
    end
  end

  // Offers one word and holds it until accepted; the predictor runs on acceptance. Valid is
  // dropped only for an idle gap, so back-to-back words keep it high.
  task automatic send_period(input in_word_t w, output out_word_t predicted);
    int burst;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      burst = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (burst) @(negedge clk);
    end
    in_word <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = fold_period(w);
    pending_results.push_back(predicted);
    @(negedge clk);
  endtask

  // A random period. Most chains are well-formed: realistic rates and accruals so the ratio
  // stays in range; the rest use raw 32-bit values to hit the clipping paths.
  function automatic in_word_t random_period(input bit wild, input bit restart);
    in_word_t w;
    w.restart = restart;
    if (wild) begin
      w.forward_rate = $urandom;
      w.accrual = $urandom;
    end else begin
      w.forward_rate = $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0200_0000;
      w.accrual = $urandom_range(0, 32'h2000_0000);
    end
    return w;
  endfunction

  initial begin
    stim_row_t   table_rows[$];
    stim_row_t   row;
    out_word_t   got_pred;
    out_word_t   ew;
    int          chain_left;
    int          n_sent;
    int          guard;
    bit          wild_chain;

    // Directed rows. A zero accrual right after reset leaves the annuity at zero.
    ew = '0;
    ew.position = 7'd1; ew.discount_ratio = ONE_Q32; ew.zero_annuity = 1'b1;
    table_rows.push_back('{word: '{32'sd0, 32'd0, 1'b0}, has_expect: 1'b1, expect_word: ew});
    // Flat forward over one year from the terminal period: ratio 1, annuity 1, swap rate 0.
    ew = '0;
    ew.position = 7'd1; ew.discount_ratio = ONE_Q32; ew.annuity = ONE_Q32;
    table_rows.push_back('{word: '{32'sd0, 32'h1000_0000, 1'b1}, has_expect: 1'b1,
                           expect_word: ew});
    table_rows.push_back('{word: '{32'sh0400_0000, 32'h1000_0000, 1'b0}, has_expect: 1'b0,
                           expect_word: '0});
    // Factor exactly zero: rate -1.0 over one year gives ratio 0 with no clip from the factor.
    table_rows.push_back('{word: '{-32'sh4000_0000, 32'h1000_0000, 1'b1}, has_expect: 1'b0,
                           expect_word: '0});
    // Negative factor: rate -2.0 over maximum accrual.
    table_rows.push_back('{word: '{32'sh8000_0000, 32'hFFFF_FFFF, 1'b1}, has_expect: 1'b0,
                           expect_word: '0});
    // Largest rate and accrual repeatedly: ratio and annuity run into saturation.
    for (int i = 0; i < 6; i++)
      table_rows.push_back('{word: '{32'sh7FFF_FFFF, 32'hFFFF_FFFF, i == 0}, has_expect: 1'b0,
                             expect_word: '0});
    table_rows.push_back('{word: '{32'sh8000_0000, 32'd1, 1'b0}, has_expect: 1'b0,
                           expect_word: '0});
    table_rows.push_back('{word: '{32'sh7FFF_FFFF, 32'd0, 1'b1}, has_expect: 1'b0,
                           expect_word: '0});
    table_rows.push_back('{word: '{-32'sd1, 32'hFFFF_FFFF, 1'b1}, has_expect: 1'b0,
                           expect_word: '0});
    table_rows.push_back('{word: '{32'sh0000_0001, 32'h0000_0001, 1'b0}, has_expect: 1'b0,
                           expect_word: '0});

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (table_rows[i]) begin
      row = table_rows[i];
      send_period(row.word, got_pred);
      if (row.has_expect && !compare_result(row.expect_word, got_pred)) n_fail++;
    end

    // Random chains. A chain that starts at word 200 is 80 words long, enough to drive the position to its ceiling.
    n_sent = 0;
    chain_left = 0;
    wild_chain = 1'b0;
    while (n_sent < N_RANDOM) begin
      if (n_sent > N_RANDOM - 150) idle_enable = 1'b0;
      if (chain_left == 0) begin
        chain_left = (n_sent == 200) ? 80 : $urandom_range(1, 40);
        wild_chain = ($urandom_range(0, 4) == 0);
        send_period(random_period(wild_chain, $urandom_range(0, 19) != 0), got_pred);
      end else begin
        send_period(random_period(wild_chain || $urandom_range(0, 49) == 0, 1'b0), got_pred);
      end
      chain_left--;
      n_sent++;
    end
    in_valid <= 1'b0;

    guard = 0;
    while (pending_results.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (60) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d result words never arrived", pending_results.size());
      n_fail++;
    end
    if (n_fail == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // About 1665 words with stalls; this timeout leaves ample margin.
  initial begin
    #10ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
